>>> rtl/core/csd_pkg.sv
package csd_pkg;

    localparam logic [1:0] OP_DECODE = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_WRITE  = 2'd2;

    localparam logic [7:0] REG_BASE0 = 8'h3c;
    localparam logic [7:0] REG_MASK0 = 8'h3d;
    localparam logic [7:0] REG_BASE1 = 8'h3e;
    localparam logic [7:0] REG_MASK1 = 8'h3f;
    localparam logic [7:0] REG_BASE2 = 8'h5c;
    localparam logic [7:0] REG_MASK2 = 8'h5d;
    localparam logic [7:0] REG_BASE3 = 8'h5e;
    localparam logic [7:0] REG_MASK3 = 8'h5f;
    localparam logic [7:0] REG_CTRL0 = 8'h68;
    localparam logic [7:0] REG_CTRL1 = 8'h69;
    localparam logic [7:0] REG_CTRL2 = 8'h6a;
    localparam logic [7:0] REG_CTRL3 = 8'h6b;

    localparam int unsigned NUM_CHAN  = 4;
    localparam int unsigned ADDR_W    = 24;

    localparam logic [2:0]  CS_NONE    = 3'd4;
    localparam logic [7:0]  BASE_RESET = 8'hff;
    localparam logic [23:0] MASK0_RESET = 24'h1fffff;
    localparam logic [23:0] MASK1_RESET = 24'h3fffff;
    localparam logic [23:0] MASK2_RESET = 24'h7fffff;
    localparam logic [23:0] MASK3_RESET = 24'h7fffff;

    typedef struct packed {
        logic [1:0]  op;
        logic [23:0] cpu_addr;
        logic [7:0]  reg_offset;
        logic [7:0]  wr_data;
    } t_csd_in;

    typedef struct packed {
        logic [7:0] read_data;
        logic [2:0] sel_chan;
    } t_csd_out;

    typedef struct packed {
        logic [NUM_CHAN-1:0][7:0]        base_high;
        logic [NUM_CHAN-1:0][ADDR_W-1:0] mask;
        logic [NUM_CHAN-1:0]             chan_enable;
        logic                            chan2_window_mode;
    } t_csd_state;

endpackage

>>> rtl/core/csd_regfile.sv
module csd_regfile (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_wr_en,
    input  logic [7:0]          i_offset,
    input  logic [7:0]          i_wr_data,
    output logic [7:0]          o_rd_data,
    output csd_pkg::t_csd_state o_state
);

    csd_pkg::t_csd_state r_state;
    csd_pkg::t_csd_state n_state;

    always_comb begin
        n_state = r_state;
        if (i_wr_en) begin
            case (i_offset)
                csd_pkg::REG_BASE0: n_state.base_high[0] = i_wr_data;
                csd_pkg::REG_BASE1: n_state.base_high[1] = i_wr_data;
                csd_pkg::REG_BASE2: n_state.base_high[2] = i_wr_data;
                csd_pkg::REG_BASE3: n_state.base_high[3] = i_wr_data;
                csd_pkg::REG_MASK0: begin
                    n_state.mask[0][8]     = i_wr_data[0];
                    n_state.mask[0][14:9]  = {6{i_wr_data[1]}};
                    n_state.mask[0][20:15] = i_wr_data[7:2];
                end
                csd_pkg::REG_MASK1: begin
                    n_state.mask[1][8]     = i_wr_data[0];
                    n_state.mask[1][15:9]  = {7{i_wr_data[1]}};
                    n_state.mask[1][21:16] = i_wr_data[7:2];
                end
                csd_pkg::REG_MASK2: n_state.mask[2][22:15] = i_wr_data;
                csd_pkg::REG_MASK3: n_state.mask[3][22:15] = i_wr_data;
                csd_pkg::REG_CTRL0: n_state.chan_enable[0] = i_wr_data[4];
                csd_pkg::REG_CTRL1: n_state.chan_enable[1] = i_wr_data[4];
                csd_pkg::REG_CTRL2: begin
                    n_state.chan_enable[2]   = i_wr_data[4];
                    n_state.chan2_window_mode = i_wr_data[3];
                end
                csd_pkg::REG_CTRL3: n_state.chan_enable[3] = i_wr_data[4];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.base_high         <= {csd_pkg::NUM_CHAN{csd_pkg::BASE_RESET}};
            r_state.mask[0]           <= csd_pkg::MASK0_RESET;
            r_state.mask[1]           <= csd_pkg::MASK1_RESET;
            r_state.mask[2]           <= csd_pkg::MASK2_RESET;
            r_state.mask[3]           <= csd_pkg::MASK3_RESET;
            r_state.chan_enable       <= '0;
            r_state.chan2_window_mode <= 1'b0;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        case (i_offset)
            csd_pkg::REG_BASE0: o_rd_data = r_state.base_high[0];
            csd_pkg::REG_BASE1: o_rd_data = r_state.base_high[1];
            csd_pkg::REG_BASE2: o_rd_data = r_state.base_high[2];
            csd_pkg::REG_BASE3: o_rd_data = r_state.base_high[3];
            csd_pkg::REG_MASK0: o_rd_data = {r_state.mask[0][20:15], r_state.mask[0][9:8]};
            csd_pkg::REG_MASK1: o_rd_data = {r_state.mask[1][21:16], r_state.mask[1][9:8]};
            csd_pkg::REG_MASK2: o_rd_data = r_state.mask[2][22:15];
            csd_pkg::REG_MASK3: o_rd_data = r_state.mask[3][22:15];
            default:            o_rd_data = 8'h00;
        endcase
    end

    assign o_state = r_state;

endmodule

>>> rtl/core/csd_decode.sv
module csd_decode (
    input  csd_pkg::t_csd_state i_state,
    input  logic [23:0]         i_addr,
    output logic [2:0]          o_sel_chan
);

    logic [csd_pkg::NUM_CHAN-1:0] w_hit;
    logic                         w_chan2_hit;

    always_comb begin
        for (int ch = 0; ch < csd_pkg::NUM_CHAN; ch++) begin
            w_hit[ch] = i_state.chan_enable[ch] &&
                        (((i_addr ^ {i_state.base_high[ch], 16'h0000}) &
                          ~i_state.mask[ch]) == 24'h000000);
        end
    end

    // Outside window mode, channel 2, when enabled, hits every address from 0x000100 upward.
    assign w_chan2_hit = i_state.chan2_window_mode ? w_hit[2] :
                         (i_state.chan_enable[2] && (|i_addr[23:8]));

    always_comb begin
        if (w_hit[0]) begin
            o_sel_chan = 3'd0;
        end else if (w_hit[1]) begin
            o_sel_chan = 3'd1;
        end else if (w_chan2_hit) begin
            o_sel_chan = 3'd2;
        end else if (w_hit[3]) begin
            o_sel_chan = 3'd3;
        end else begin
            o_sel_chan = csd_pkg::CS_NONE;
        end
    end

endmodule

>>> rtl/core/chip_select_decoder_regs_unit.sv
// Chip-select decoder with a four-channel register file.
// The input channel carries one word per operation: an address decode, a register
// read or a register write. The output channel returns one word per input word,
// in order, holding the read data and the selected channel (4 when none).
// Both channels use valid and stall; a word moves at a clock edge where valid is
// high and stall is low.
// An accepted word sits in the input register, is decoded or applied to the
// register file there, and its result word is presented in the output register.
// When nothing stalls, one word is accepted every cycle; the rate is set by the
// single pass from the input register through the decode or register access to
// the output register.
// Register writes take effect in order, so a later word sees every earlier write.
// When the receiver stalls, the output word holds and the input register fills;
// the input stall rises with the output stall once the input register holds a word.
// Synchronous reset restores all bases to 0xFF, the masks to their default
// values, clears every channel enable and the channel 2 window mode, and empties
// both registers.
module chip_select_decoder_regs_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  csd_pkg::t_csd_in  i_in_word,
    output logic              o_in_stall,
    output logic              o_out_valid,
    output csd_pkg::t_csd_out o_out_word,
    input  logic              i_out_stall
);

    logic                r_in_valid;
    csd_pkg::t_csd_in    r_in;
    logic                r_out_valid;
    csd_pkg::t_csd_out   r_out;
    csd_pkg::t_csd_out   n_out;

    logic                w_out_free;
    logic                w_proc;
    logic                w_wr_en;
    logic [7:0]          w_rd_data;
    logic [2:0]          w_cs;
    csd_pkg::t_csd_state w_state;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_proc     = r_in_valid && w_out_free;
    assign w_wr_en    = w_proc && (r_in.op == csd_pkg::OP_WRITE);
    assign o_in_stall = r_in_valid && !w_out_free;

    csd_regfile u_regfile (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_wr_en),
        .i_offset  (r_in.reg_offset),
        .i_wr_data (r_in.wr_data),
        .o_rd_data (w_rd_data),
        .o_state   (w_state)
    );

    csd_decode u_decode (
        .i_state    (w_state),
        .i_addr     (r_in.cpu_addr),
        .o_sel_chan (w_cs)
    );

    always_comb begin
        n_out.read_data = (r_in.op == csd_pkg::OP_READ) ? w_rd_data : 8'h00;
        n_out.sel_chan  = (r_in.op == csd_pkg::OP_DECODE) ? w_cs : csd_pkg::CS_NONE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (w_out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_word;
        end
        if (w_proc) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid)
        else $error("input stall raised with an empty input register");

    a_proc_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_proc |=> r_out_valid)
        else $error("processed word did not reach the output register");

    a_no_enable_no_select: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_proc && (r_in.op == csd_pkg::OP_DECODE) && (w_state.chan_enable == '0))
        |=> (o_out_word.sel_chan == csd_pkg::CS_NONE))
        else $error("decode selected a channel while all channels are disabled");

    a_read_excludes_select: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_word.read_data != 8'h00))
        |-> (o_out_word.sel_chan == csd_pkg::CS_NONE))
        else $error("result word carries both read data and a chip select");

endmodule
